### sv/tevc_pkg.sv
// Shared types and constants of the tree ensemble vote classifier.
package tevc_pkg;

	// Field widths of the request and result channels
	localparam int FUNC_W    = 2;
	localparam int TREE_W    = 6;
	localparam int NODE_W    = 8;
	localparam int FEAT_W    = 7;
	localparam int BYTE_W    = 8;
	localparam int CLASS_W   = 4;
	localparam int PRED_W    = 5;
	localparam int WORD_W    = 31;
	localparam int CFG_W     = 7;
	localparam int TCOUNT_W  = 7;
	localparam int CCOUNT_W  = 5;
	localparam int CFG_IDX_W = 1;

	// Request function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_NODE     = 2'd0,
		FUNC_FEAT     = 2'd1,
		FUNC_CLASSIFY = 2'd2
	} func_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TREE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TREE,
		ST_NODE,
		ST_FEAT,
		ST_VOTE,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	// Commands to the vote counter memory
	typedef struct packed {
		logic clear;
		logic rd;
		logic inc;
	} vote_ctl_t;

	localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

endpackage

### sv/tevc_ifs.sv
// Request and result channel interfaces of the tree ensemble vote classifier.
interface tevc_req_if;
	logic                         valid;
	logic                         ready;
	logic [tevc_pkg::FUNC_W-1:0]  func;
	logic [tevc_pkg::TREE_W-1:0]  tree_index;
	logic [tevc_pkg::NODE_W-1:0]  node_index;
	logic [tevc_pkg::FEAT_W-1:0]  node_feature;
	logic [tevc_pkg::BYTE_W-1:0]  node_threshold;
	logic [tevc_pkg::NODE_W-1:0]  left_child;
	logic [tevc_pkg::NODE_W-1:0]  right_child;
	logic [tevc_pkg::FEAT_W-1:0]  feature_index;
	logic [tevc_pkg::BYTE_W-1:0]  feature_value;

	modport source(
		output valid, func, tree_index, node_index, node_feature, node_threshold,
		left_child, right_child, feature_index, feature_value,
		input ready
	);
	modport sink(
		input valid, func, tree_index, node_index, node_feature, node_threshold,
		left_child, right_child, feature_index, feature_value,
		output ready
	);
endinterface

interface tevc_res_if;
	logic                         valid;
	logic                         ready;
	logic [tevc_pkg::CLASS_W-1:0] class_index;
	logic [tevc_pkg::BYTE_W-1:0]  vote_count;
	logic [tevc_pkg::PRED_W-1:0]  predicted_class;
	logic                         walk_error;
	logic                         last;

	modport source(
		output valid, class_index, vote_count, predicted_class, walk_error, last,
		input ready
	);
	modport sink(
		input valid, class_index, vote_count, predicted_class, walk_error, last,
		output ready
	);
endinterface

### sv/tevc_votes.sv
// Vote counter memory with per-entry valid bits and saturating increment.
module tevc_votes #(
	parameter int MAX_CLASSES = 16,
	localparam int CA = $clog2(MAX_CLASSES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tevc_pkg::vote_ctl_t         ctl,
	input  logic [CA-1:0]               addr,
	output logic [tevc_pkg::BYTE_W-1:0] count
);

	logic [tevc_pkg::BYTE_W-1:0] mem [MAX_CLASSES];
	logic [MAX_CLASSES-1:0]      vld_q;
	logic [tevc_pkg::BYTE_W-1:0] rdata_q;
	logic                        hit_q;
	logic [tevc_pkg::BYTE_W-1:0] count_inc;

	// entries not written since the last clear read as zero
	assign count     = hit_q ? rdata_q : '0;
	assign count_inc = (count == tevc_pkg::COUNT_MAX) ? count : count + 8'd1;

	// counter storage: read, then write back the incremented value
	always_ff @(posedge clk) begin
		if (ctl.inc) begin
			mem[addr] <= count_inc;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	// valid bits, cleared at the start of each classify run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				vld_q <= '0;
			end else if (ctl.inc) begin
				vld_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				hit_q <= vld_q[addr] & ~ctl.clear;
			end
		end
	end

endmodule

### sv/tree_ensemble_vote_classifier.sv
// Top level of the tree ensemble vote classifier: stores, tree walker, vote output.
//
//  channel   dir   handshake       payload
//  req       in    valid/ready     func, tree/node write fields, feature write fields
//  res       out   valid/ready     class_index, vote_count, predicted_class, walk_error, last
//  cfg       in    cfg_we          cfg_index, cfg_data (tree_count, class_count)
//
// Node and feature writes are stored when the request is taken. A classify
// request walks each configured tree and then reads out the vote counters: every
// move of a walk is one feature memory read followed by one node memory read.
// Requests are taken only while the sequencer is idle; the last result may
// still wait in the output register while the next request is taken.
// Reset clears control state and the vote valid bits; node and feature stores
// are undefined until written.
module tree_ensemble_vote_classifier #(
	parameter int MAX_TREES      = 64,
	parameter int NODES_PER_TREE = 256,
	parameter int FEATURE_COUNT  = 128,
	parameter int MAX_CLASSES    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tevc_req_if.sink                             req,
	tevc_res_if.source                           res,
	input  logic                                 cfg_we,
	input  logic [tevc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tevc_pkg::CFG_W-1:0]           cfg_data
);

	localparam int TA  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int TW  = $clog2(MAX_TREES + 1);
	localparam int NA  = $clog2(NODES_PER_TREE);
	localparam int MW  = $clog2(NODES_PER_TREE + 1);
	localparam int FA  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int CA  = $clog2(MAX_CLASSES);
	localparam int CCW = $clog2(MAX_CLASSES + 1);
	localparam int NODE_DEPTH = MAX_TREES * (1 << NA);

	tevc_pkg::state_t state_q, state_n;

	// configuration registers
	logic [tevc_pkg::TCOUNT_W-1:0] tree_count_q;
	logic [tevc_pkg::CCOUNT_W-1:0] class_count_q;

	// stores
	logic [tevc_pkg::WORD_W-1:0] node_mem [NODE_DEPTH];
	logic [tevc_pkg::BYTE_W-1:0] feat_mem [FEATURE_COUNT];
	logic [tevc_pkg::WORD_W-1:0] node_rdata_q;
	logic [tevc_pkg::BYTE_W-1:0] feat_rdata_q;

	// walk state
	logic [TA-1:0]              t_q;
	logic [TW-1:0]              trees_q;
	logic [CCW-1:0]             classes_q;
	logic [MW-1:0]              moves_q;
	logic                       root_q;
	logic                       oor_q;
	logic                       foor_q;
	logic                       err_q;
	logic [tevc_pkg::BYTE_W-1:0] thr_q;
	logic [tevc_pkg::NODE_W-1:0] left_q;
	logic [tevc_pkg::NODE_W-1:0] right_q;
	logic [CA-1:0]              vaddr_q;
	logic [CA-1:0]              c_q;
	logic [CA-1:0]              best_q;
	logic [tevc_pkg::BYTE_W-1:0] best_cnt_q;

	// output register
	logic                        out_vld_q;
	logic [tevc_pkg::CLASS_W-1:0] out_class_q;
	logic [tevc_pkg::BYTE_W-1:0]  out_count_q;
	logic [tevc_pkg::PRED_W-1:0]  out_pred_q;
	logic                        out_err_q;
	logic                        out_last_q;

	// combinational
	logic                        req_acc;
	tevc_pkg::func_t             func;
	logic                        node_we, feat_we;
	logic                        node_re, feat_re;
	logic [TA+NA-1:0]            node_waddr, node_raddr;
	logic [FA-1:0]               feat_raddr;
	logic [tevc_pkg::WORD_W-1:0] word;
	logic [tevc_pkg::FEAT_W-1:0] w_feat;
	logic [tevc_pkg::BYTE_W-1:0] w_thr;
	logic [tevc_pkg::NODE_W-1:0] w_left, w_right;
	logic                        is_leaf, walk_over, leaf_votes, last_tree;
	logic [tevc_pkg::BYTE_W-1:0] fbyte;
	logic [tevc_pkg::NODE_W-1:0] child;
	logic                        slot_free, last_class;
	logic [TW-1:0]               trees_eff;
	logic [CCW-1:0]              classes_eff;
	tevc_pkg::vote_ctl_t         vctl;
	logic [CA-1:0]               vaddr;
	logic [tevc_pkg::BYTE_W-1:0] vcount;
	logic                        new_best;
	logic [CA-1:0]               best_n;

	assign req_acc = req.valid && req.ready;
	assign func    = tevc_pkg::func_t'(req.func);
	assign req.ready = (state_q == tevc_pkg::ST_IDLE);

	// node word as seen by the walker; an out-of-range child reads as zero
	assign word    = oor_q ? '0 : node_rdata_q;
	assign w_feat  = word[6:0];
	assign w_thr   = word[14:7];
	assign w_left  = word[22:15];
	assign w_right = word[30:23];

	assign is_leaf    = !root_q && (w_right == '0);
	assign walk_over  = (moves_q >= MW'(NODES_PER_TREE));
	assign leaf_votes = (32'(w_feat) < 32'(classes_q));
	assign last_tree  = (TW'(t_q) + TW'(1) >= trees_q);

	// branch decision
	assign fbyte = foor_q ? '0 : feat_rdata_q;
	assign child = (fbyte <= thr_q) ? left_q : right_q;

	assign slot_free  = !out_vld_q || res.ready;
	assign last_class = (CCW'(c_q) + CCW'(1) == classes_q);

	// effective counts taken at classify
	always_comb begin
		if (32'(tree_count_q) > MAX_TREES) begin
			trees_eff = TW'(MAX_TREES);
		end else begin
			trees_eff = TW'(tree_count_q);
		end
		if (class_count_q == '0) begin
			classes_eff = CCW'(1);
		end else if (32'(class_count_q) > MAX_CLASSES) begin
			classes_eff = CCW'(MAX_CLASSES);
		end else begin
			classes_eff = CCW'(class_count_q);
		end
	end

	// store addresses
	assign node_waddr = {TA'(req.tree_index), NA'(req.node_index)};
	assign feat_raddr = FA'(w_feat);
	assign node_we = req_acc && (func == tevc_pkg::FUNC_NODE)
		&& (32'(req.tree_index) < MAX_TREES) && (32'(req.node_index) < NODES_PER_TREE);
	assign feat_we = req_acc && (func == tevc_pkg::FUNC_FEAT)
		&& (32'(req.feature_index) < FEATURE_COUNT);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tevc_pkg::ST_IDLE: begin
				if (req_acc && func == tevc_pkg::FUNC_CLASSIFY) begin
					state_n = (trees_eff == '0) ? tevc_pkg::ST_OUT_RD : tevc_pkg::ST_TREE;
				end
			end
			tevc_pkg::ST_TREE: state_n = tevc_pkg::ST_NODE;
			tevc_pkg::ST_NODE: begin
				if (is_leaf) begin
					if (leaf_votes) begin
						state_n = tevc_pkg::ST_VOTE;
					end else begin
						state_n = last_tree ? tevc_pkg::ST_OUT_RD : tevc_pkg::ST_TREE;
					end
				end else if (walk_over) begin
					state_n = last_tree ? tevc_pkg::ST_OUT_RD : tevc_pkg::ST_TREE;
				end else begin
					state_n = tevc_pkg::ST_FEAT;
				end
			end
			tevc_pkg::ST_FEAT: state_n = tevc_pkg::ST_NODE;
			tevc_pkg::ST_VOTE: state_n = last_tree ? tevc_pkg::ST_OUT_RD : tevc_pkg::ST_TREE;
			tevc_pkg::ST_OUT_RD: state_n = tevc_pkg::ST_OUT_LD;
			tevc_pkg::ST_OUT_LD: begin
				if (slot_free) begin
					state_n = last_class ? tevc_pkg::ST_IDLE : tevc_pkg::ST_OUT_RD;
				end
			end
			default: state_n = tevc_pkg::ST_IDLE;
		endcase
	end

	// memory commands per state
	always_comb begin
		node_re    = 1'b0;
		node_raddr = {t_q, NA'(child)};
		feat_re    = 1'b0;
		vctl       = '0;
		vaddr      = CA'(w_feat);
		unique case (state_q)
			tevc_pkg::ST_IDLE: begin
				vctl.clear = req_acc && (func == tevc_pkg::FUNC_CLASSIFY);
			end
			tevc_pkg::ST_TREE: begin
				node_re    = 1'b1;
				node_raddr = {t_q, NA'(0)};
			end
			tevc_pkg::ST_NODE: begin
				feat_re = !is_leaf && !walk_over;
				vctl.rd = is_leaf && leaf_votes;
			end
			tevc_pkg::ST_FEAT: begin
				node_re = 1'b1;
			end
			tevc_pkg::ST_VOTE: begin
				vctl.inc = 1'b1;
				vaddr    = vaddr_q;
			end
			tevc_pkg::ST_OUT_RD: begin
				vctl.rd = 1'b1;
				vaddr   = c_q;
			end
			tevc_pkg::ST_OUT_LD: begin
				vaddr = c_q;
			end
			default: begin
			end
		endcase
	end

	// node and feature stores
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= {req.right_child, req.left_child,
				req.node_threshold, req.node_feature};
		end
		if (node_re) begin
			node_rdata_q <= node_mem[node_raddr];
		end
		if (feat_we) begin
			feat_mem[FA'(req.feature_index)] <= req.feature_value;
		end
		if (feat_re) begin
			feat_rdata_q <= feat_mem[feat_raddr];
		end
	end

	tevc_votes #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_votes (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (vctl),
		.addr  (vaddr),
		.count (vcount)
	);

	// running first maximum over the reported classes
	assign new_best = (c_q == '0) || (vcount > best_cnt_q);
	assign best_n   = new_best ? c_q : best_q;

	// sequencer and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tevc_pkg::ST_IDLE;
			tree_count_q  <= tevc_pkg::TCOUNT_W'(1);
			class_count_q <= tevc_pkg::CCOUNT_W'(2);
			t_q           <= '0;
			trees_q       <= '0;
			classes_q     <= '0;
			moves_q       <= '0;
			root_q        <= 1'b0;
			oor_q         <= 1'b0;
			foor_q        <= 1'b0;
			err_q         <= 1'b0;
			c_q           <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				unique case (cfg_index)
					tevc_pkg::REG_TREE_COUNT:  tree_count_q  <= cfg_data;
					tevc_pkg::REG_CLASS_COUNT: class_count_q <= cfg_data[tevc_pkg::CCOUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				tevc_pkg::ST_IDLE: begin
					if (req_acc && func == tevc_pkg::FUNC_CLASSIFY) begin
						trees_q   <= trees_eff;
						classes_q <= classes_eff;
						t_q       <= '0;
						c_q       <= '0;
						err_q     <= 1'b0;
					end
				end
				tevc_pkg::ST_TREE: begin
					moves_q <= '0;
					root_q  <= 1'b1;
					oor_q   <= 1'b0;
				end
				tevc_pkg::ST_NODE: begin
					foor_q <= (32'(w_feat) >= FEATURE_COUNT);
					if (!is_leaf && walk_over) begin
						err_q <= 1'b1;
					end
					if ((is_leaf && !leaf_votes) || (!is_leaf && walk_over)) begin
						t_q <= t_q + TA'(1);
					end
				end
				tevc_pkg::ST_FEAT: begin
					moves_q <= moves_q + MW'(1);
					root_q  <= 1'b0;
					oor_q   <= (32'(child) >= NODES_PER_TREE);
				end
				tevc_pkg::ST_VOTE: begin
					t_q <= t_q + TA'(1);
				end
				tevc_pkg::ST_OUT_LD: begin
					if (slot_free) begin
						out_vld_q <= 1'b1;
						c_q       <= c_q + CA'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// walk and result payload registers
	always_ff @(posedge clk) begin
		if (state_q == tevc_pkg::ST_NODE) begin
			thr_q   <= w_thr;
			left_q  <= w_left;
			right_q <= w_right;
			vaddr_q <= CA'(w_feat);
		end
		if (state_q == tevc_pkg::ST_OUT_LD && slot_free) begin
			best_q      <= best_n;
			best_cnt_q  <= new_best ? vcount : best_cnt_q;
			out_class_q <= tevc_pkg::CLASS_W'(c_q);
			out_count_q <= vcount;
			out_pred_q  <= last_class ? tevc_pkg::PRED_W'(best_n) + tevc_pkg::PRED_W'(1) : '0;
			out_err_q   <= err_q;
			out_last_q  <= last_class;
		end
	end

	assign res.valid           = out_vld_q;
	assign res.class_index     = out_class_q;
	assign res.vote_count      = out_count_q;
	assign res.predicted_class = out_pred_q;
	assign res.walk_error      = out_err_q;
	assign res.last            = out_last_q;

	// a walk never goes past the node count of a tree
	assert property (@(posedge clk) disable iff (!arst_n)
		moves_q <= MW'(NODES_PER_TREE))
		else $error("walk move counter beyond node count");

	// every counter increment follows a read of the same entry
	assert property (@(posedge clk) disable iff (!arst_n)
		vctl.inc |-> $past(vctl.rd) && ($past(vaddr) == vaddr))
		else $error("vote increment without matching read");

	// only the last result of a run carries a prediction
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> res.predicted_class == '0)
		else $error("prediction on a non-final result");

endmodule
